FILE: rtl/nsd_pkg.sv
// Package for the noise squelch detector: field widths, reset values,
// register indexes, the event code type and the item structs.
// Depends on nothing; every other file of the block imports it.
package nsd_pkg;

	// Field and state widths fixed by the item format.
	localparam int unsigned SMP_W     = 16;
	localparam int unsigned SUM_W     = 26;
	localparam int unsigned CI_W      = 4;
	localparam int unsigned DUR_W     = 27;
	localparam int unsigned POS_W     = 32;
	localparam int unsigned REG_IDX_W = 2;

	// Reset values of the registers and of the leaky sum.
	localparam logic [SUM_W-1:0] OPEN_TH_RESET  = 26'd1800000;
	localparam logic [SUM_W-1:0] CLOSE_TH_RESET = 26'd4080000;
	localparam logic [CI_W-1:0]  CHECK_RESET    = 4'd15;

	// Lowest value the peak tracker restarts from.
	localparam logic signed [SMP_W-1:0] PEAK_FLOOR = -16'sd32000;

	// Milliseconds per second, used by the open-time counter.
	localparam int unsigned MS_PER_S = 1000;

	// Largest reportable open time.
	localparam logic [DUR_W-1:0] DUR_MAX = '1;

	// Configuration register indexes.
	localparam logic [REG_IDX_W-1:0] REG_OPEN_TH  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_CLOSE_TH = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_CHECK    = 2'd2;

	// Squelch events reported with each result item.
	typedef enum logic [1:0] {
		EV_NONE     = 2'd0,
		EV_OPENED   = 2'd1,
		EV_CLOSED   = 2'd2,
		EV_REOPENED = 2'd3
	} event_t;

	// One input item.
	typedef struct packed {
		logic signed [SMP_W-1:0] raw_sample;
		logic signed [SMP_W-1:0] hp_sample;
		logic                    block_start;
	} in_item_t;

	// One result item.
	typedef struct packed {
		logic                    squelch_open;
		event_t                  event_res;
		logic [DUR_W-1:0]        open_duration_ms;
		logic signed [SMP_W-1:0] peak;
	} out_item_t;

endpackage

FILE: rtl/nsd_if.sv
// Handshake channels of the noise squelch detector: sample items, result
// items and configuration writes. Depends on nsd_pkg for the item types.

// Channel that moves input sample items.
interface nsd_in_if;
	import nsd_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// Channel that moves result items.
interface nsd_out_if;
	import nsd_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// Register write channel.
interface nsd_cfg_if;
	import nsd_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [REG_IDX_W-1:0] addr;
	logic [SUM_W-1:0]     wdata;
	modport source(output valid, output addr, output wdata, input ready);
	modport sink(input valid, input addr, input wdata, output ready);
endinterface

FILE: rtl/noise_squelch_detector_core.sv
// Noise squelch detector with hysteresis: one sample item in, one result out.
// Depends on nsd_pkg and the channel interfaces in nsd_if.sv.
//
// The block accepts one item per clock cycle unless results.ready stalls it;
// the item is registered, then the leaky noise sum, squelch decision, open-time
// count and peak are worked out combinationally into the result register. The
// cycle is set by the leaky sum update (a 26 x 28 bit reciprocal multiply for
// the decay, a subtract, an add with saturation and the threshold compares),
// since each item needs the sum left by the one before. The open time is
// counted in milliseconds while the squelch runs, so no divider is needed at
// close. Configuration writes are always taken and apply from the next item
// worked on; write them only while no item is in flight.
module noise_squelch_detector_core #(
	parameter int unsigned DECAY_DIV   = 1200,
	parameter int unsigned AUDIO_FS_HZ = 48000
) (
	input logic       clk,
	input logic       arst_n,
	nsd_in_if.sink    samples,
	nsd_out_if.source results,
	nsd_cfg_if.sink   cfg
);
	import nsd_pkg::*;

	// Reciprocal for the decay divide, exact for every 26 bit sum.
	localparam int unsigned DIV_LOG = $clog2(DECAY_DIV);
	localparam int unsigned RCP_SH  = SUM_W + DIV_LOG;
	localparam int unsigned RCP_W   = SUM_W + 2;
	localparam longint unsigned RCP_L =
		((64'd1 << RCP_SH) + longint'(DECAY_DIV) - 64'd1) / longint'(DECAY_DIV);
	localparam logic [RCP_W-1:0] RCP = RCP_L[RCP_W-1:0];

	// Remainder of the millisecond counter stays below the sample rate.
	localparam int unsigned REM_W = $clog2(AUDIO_FS_HZ + MS_PER_S);
	localparam logic [REM_W-1:0] REM_STEP = REM_W'(MS_PER_S);
	localparam logic [REM_W-1:0] REM_WRAP = REM_W'(AUDIO_FS_HZ);

	// Configuration registers.
	logic [SUM_W-1:0] open_th_q;
	logic [SUM_W-1:0] close_th_q;
	logic [CI_W-1:0]  check_int_q;

	// Squelch state.
	logic [SUM_W-1:0]        level_sum_q;
	logic [CI_W-1:0]         check_count_q;
	logic [POS_W-1:0]        open_span_q;
	logic [POS_W-1:0]        open_ms_q;
	logic [REM_W-1:0]        ms_rem_q;
	logic                    is_open_q;
	logic signed [SMP_W-1:0] block_peak_q;

	// Pipeline registers.
	logic      valid_s1;
	in_item_t  item_s1;
	logic      valid_s2;
	out_item_t res_s2;

	// Handshake.
	logic adv_s2;
	logic fire_s1;

	// Update logic.
	logic [SUM_W+RCP_W-1:0]  decay_prod;
	logic [SUM_W+RCP_W-1:0]  decay_shift;
	logic [SUM_W-1:0]        decay_quot;
	logic [SUM_W-1:0]        sum_dec;
	logic [SMP_W-1:0]        hp_abs;
	logic [SUM_W:0]          sum_add;
	logic [SUM_W-1:0]        sum_next;
	logic [CI_W-1:0]         count_inc;
	logic                    check_hit;
	logic                    do_close;
	logic                    do_open;
	logic                    open_next;
	logic [POS_W-1:0]        span_inc;
	logic                    span_wrap;
	logic [REM_W-1:0]        rem_sum;
	logic                    ms_carry;
	logic [REM_W-1:0]        rem_inc;
	logic [POS_W-1:0]        ms_inc;
	logic [DUR_W-1:0]        dur_sat;
	logic signed [SMP_W-1:0] peak_base;
	logic signed [SMP_W-1:0] peak_next;
	event_t                  ev;

	// Each stage moves on when its successor has room.
	assign adv_s2        = !valid_s2 || results.ready;
	assign samples.ready = !valid_s1 || adv_s2;
	assign fire_s1       = valid_s1 && adv_s2;
	assign cfg.ready     = 1'b1;

	assign results.valid = valid_s2;
	assign results.data  = res_s2;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_th_q   <= OPEN_TH_RESET;
			close_th_q  <= CLOSE_TH_RESET;
			check_int_q <= CHECK_RESET;
		end else if (cfg.valid) begin
			if (cfg.addr == REG_OPEN_TH) begin
				open_th_q <= cfg.wdata;
			end
			if (cfg.addr == REG_CLOSE_TH) begin
				close_th_q <= cfg.wdata;
			end
			if (cfg.addr == REG_CHECK) begin
				check_int_q <= cfg.wdata[CI_W-1:0];
			end
		end
	end

	// Leaky sum: drop sum/DECAY_DIV, add the absolute filtered sample, saturate.
	always_comb begin
		decay_prod  = (SUM_W+RCP_W)'(level_sum_q) * (SUM_W+RCP_W)'(RCP);
		decay_shift = decay_prod >> RCP_SH;
		decay_quot  = decay_shift[SUM_W-1:0];
		sum_dec     = level_sum_q - decay_quot;
		hp_abs      = item_s1.hp_sample[SMP_W-1] ? (~item_s1.hp_sample + 1'b1)
			: item_s1.hp_sample;
		sum_add     = {1'b0, sum_dec} + (SUM_W+1)'(hp_abs);
		sum_next    = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
	end

	// Check counter and squelch decision with hysteresis.
	always_comb begin
		count_inc = check_count_q + 1'b1;
		check_hit = (count_inc == check_int_q);
		do_close  = check_hit && is_open_q && (sum_next > close_th_q);
		open_next = is_open_q && !do_close;
		do_open   = check_hit && !open_next && (sum_next < open_th_q);
		ev        = event_t'({do_close, do_open});
	end

	// Open time in ms, counted per item: floor(span * 1000 / AUDIO_FS_HZ).
	always_comb begin
		span_inc  = open_span_q + 1'b1;
		span_wrap = (span_inc == '0);
		rem_sum   = ms_rem_q + REM_STEP;
		ms_carry  = (rem_sum >= REM_WRAP);
		rem_inc   = ms_carry ? (rem_sum - REM_WRAP) : rem_sum;
		ms_inc    = open_ms_q + POS_W'(ms_carry);
		if (span_wrap) begin
			rem_inc = '0;
			ms_inc  = '0;
		end
		dur_sat = (|ms_inc[POS_W-1:DUR_W]) ? DUR_MAX : ms_inc[DUR_W-1:0];
	end

	// Running peak of the raw samples since the last block start.
	always_comb begin
		peak_base = item_s1.block_start ? PEAK_FLOOR : block_peak_q;
		peak_next = (item_s1.raw_sample > peak_base) ? item_s1.raw_sample : peak_base;
	end

	// State update, once for each item leaving the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_sum_q   <= CLOSE_TH_RESET;
			check_count_q <= '0;
			open_span_q   <= '0;
			open_ms_q     <= '0;
			ms_rem_q      <= '0;
			is_open_q     <= 1'b0;
			block_peak_q  <= PEAK_FLOOR;
		end else if (fire_s1) begin
			level_sum_q   <= sum_next;
			check_count_q <= check_hit ? '0 : count_inc;
			is_open_q     <= open_next || do_open;
			block_peak_q  <= peak_next;
			if (do_open) begin
				open_span_q <= '0;
				open_ms_q   <= '0;
				ms_rem_q    <= '0;
			end else begin
				open_span_q <= span_inc;
				open_ms_q   <= ms_inc;
				ms_rem_q    <= rem_inc;
			end
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			item_s1 <= samples.data;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			res_s2.squelch_open     <= open_next || do_open;
			res_s2.event_res        <= ev;
			res_s2.open_duration_ms <= do_close ? dur_sat : '0;
			res_s2.peak             <= peak_next;
		end
	end

`ifndef SYNTHESIS
	// The reported state agrees with the event: an open ends open, a close ends shut.
	a_event_state: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && (results.data.event_res == EV_OPENED
			|| results.data.event_res == EV_REOPENED)
		|-> results.data.squelch_open)
		else $error("open event reported with squelch shut");

	a_close_state: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.data.event_res == EV_CLOSED
		|-> !results.data.squelch_open)
		else $error("close event reported with squelch open");

	// An open time is only ever reported with a close.
	a_dur_on_close: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && !results.data.event_res[1]
		|-> results.data.open_duration_ms == '0)
		else $error("open time reported without a close");

	// The squelch only changes state when an item is worked on.
	a_open_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!fire_s1 |=> $stable(is_open_q))
		else $error("squelch state changed without an item");

	// The millisecond remainder stays below the sample rate.
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		ms_rem_q < REM_WRAP)
		else $error("open-time remainder out of range");
`endif

endmodule
